// ===== hdl/psg_pkg.sv =====
// Shared types and constants for the sound-register dump parser.
// No dependencies; the front end, queue, back end and top level import this package.
`default_nettype none

package psg_pkg;

    // Register image geometry.
    localparam int REGISTER_COUNT = 14;
    localparam int IMAGE_HALF     = 7;
    localparam int HALF_W         = 8 * IMAGE_HALF;
    localparam int SPAN_W         = 16;

    // Index of the envelope-shape register that a new group marks as unwritten.
    localparam logic [3:0] SHAPE_REG      = 4'd13;
    localparam logic [7:0] SHAPE_NO_WRITE = 8'hFF;

    // Command bytes.
    localparam logic [7:0] CMD_END   = 8'hFD;
    localparam logic [7:0] CMD_PAUSE = 8'hFE;
    localparam logic [7:0] CMD_FRAME = 8'hFF;

    localparam logic [SPAN_W-1:0] TALLY_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_GROUP = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } record_kind_t;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_CMD   = 5'b00001,
        PH_VALUE = 5'b00010,
        PH_PAUSE = 5'b00100,
        PH_DONE  = 5'b01000,
        PH_ERROR = 5'b10000
    } phase_t;

    // One queue entry: the records caused by one byte.
    // An optional frame group, then an optional end or error record.
    typedef struct packed {
        logic              has_group;
        logic [HALF_W-1:0] image_low;
        logic [HALF_W-1:0] image_high;
        logic [SPAN_W-1:0] span;
        logic              has_term;
        record_kind_t      term_kind;
    } entry_t;

endpackage

`default_nettype wire

// ===== hdl/psg_byte_if.sv =====
// Handshake interface for the incoming dump byte stream.
// Plain valid/ready channel; no package dependency.
`default_nettype none

interface psg_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/psg_record_if.sv =====
// Handshake interface for the outgoing record stream.
// Plain valid/ready channel; no package dependency.
`default_nettype none

interface psg_record_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [55:0] image_low;
    logic [55:0] image_high;
    logic [15:0] frame_span;
    logic        run_end;

    modport source (output valid, output record_kind, output image_low, output image_high,
                    output frame_span, output run_end, input ready);
    modport sink   (input valid, input record_kind, input image_low, input image_high,
                    input frame_span, input run_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/psg_front.sv =====
// Front end: accepts dump bytes, runs the parser state and builds queue entries.
// Depends on psg_pkg and psg_byte_if.
`default_nettype none

module psg_front
    import psg_pkg::*;
#(
    parameter int HEADER_BYTES = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    psg_byte_if.sink    bytes,
    input  wire logic   q_full,
    output logic        push,
    output entry_t      entry
);

    localparam int HL_W = $clog2(HEADER_BYTES + 1);

    logic [7:0]        image_reg  [REGISTER_COUNT];
    logic [7:0]        image_next [REGISTER_COUNT];
    logic [HL_W-1:0]   header_left_reg, header_left_next;
    phase_t            phase_reg, phase_next;
    logic [3:0]        pending_reg, pending_next;
    logic [SPAN_W-1:0] tally_reg, tally_next;
    logic              delim_reg, delim_next;
    logic              open_reg, open_next;

    logic              accept;
    logic [7:0]        b;
    logic              fin;
    logic              finish_req;
    logic              fail_req;
    logic [9:0]        pause_add;
    logic [17:0]       pause_sum;
    logic [16:0]       frame_sum;

    assign bytes.ready = !q_full;
    assign accept      = bytes.valid && bytes.ready;
    assign b           = bytes.data_byte;
    assign fin         = bytes.final_byte;
    assign pause_add   = {b, 2'b00};

    // Parser next state and entry contents for the current byte.
    always_comb
    begin
        image_next       = image_reg;
        header_left_next = header_left_reg;
        phase_next       = phase_reg;
        pending_next     = pending_reg;
        tally_next       = tally_reg;
        delim_next       = delim_reg;
        open_next        = open_reg;
        finish_req       = 1'b0;
        fail_req         = 1'b0;
        pause_sum        = '0;
        frame_sum        = '0;
        entry            = '0;
        entry.term_kind  = KIND_END;

        if (phase_reg == PH_CMD || phase_reg == PH_VALUE || phase_reg == PH_PAUSE)
        begin
            if (header_left_reg != '0)
            begin
                header_left_next = header_left_reg - HL_W'(1);
                finish_req       = fin;
            end
            else if (phase_reg == PH_VALUE)
            begin
                // Registers 14 and 15 are read and dropped.
                for (int i = 0; i < REGISTER_COUNT; i++)
                begin
                    if (pending_reg == 4'(i))
                        image_next[i] = b;
                end
                phase_next = PH_CMD;
                finish_req = fin;
            end
            else if (phase_reg == PH_PAUSE)
            begin
                // Add four frames per count, one less when no delimiter came first.
                pause_sum = 18'(tally_reg) + 18'(pause_add) - (delim_reg ? 18'd0 : 18'd1);
                if (pause_sum > 18'(TALLY_MAX))
                    tally_next = TALLY_MAX;
                else
                    tally_next = pause_sum[SPAN_W-1:0];
                delim_next = 1'b1;
                phase_next = PH_CMD;
                finish_req = fin;
            end
            else if (b == CMD_END)
            begin
                finish_req = 1'b1;
            end
            else if (b == CMD_FRAME)
            begin
                if (!open_reg)
                begin
                    image_next[SHAPE_REG] = SHAPE_NO_WRITE;
                    tally_next            = 16'd1;
                    delim_next            = 1'b0;
                    open_next             = 1'b1;
                end
                if (delim_next)
                begin
                    frame_sum = 17'(tally_next) + 17'd1;
                    tally_next = frame_sum[SPAN_W] ? TALLY_MAX : frame_sum[SPAN_W-1:0];
                end
                else
                begin
                    delim_next = 1'b1;
                end
                finish_req = fin;
            end
            else if (b == CMD_PAUSE)
            begin
                if (!open_reg)
                begin
                    image_next[SHAPE_REG] = SHAPE_NO_WRITE;
                    tally_next            = 16'd1;
                    delim_next            = 1'b0;
                    open_next             = 1'b1;
                end
                if (fin)
                    fail_req = 1'b1;
                else
                    phase_next = PH_PAUSE;
            end
            else if (b[7:4] == 4'd0)
            begin
                // A register byte after a delimiter closes the group with its old image.
                if (open_reg && delim_reg)
                begin
                    if (tally_reg != '0)
                    begin
                        entry.has_group = 1'b1;
                        for (int i = 0; i < IMAGE_HALF; i++)
                        begin
                            entry.image_low[8*i +: 8]  = image_reg[i];
                            entry.image_high[8*i +: 8] = image_reg[IMAGE_HALF + i];
                        end
                        entry.span = tally_reg;
                    end
                    open_next = 1'b0;
                end
                if (!open_next)
                begin
                    image_next[SHAPE_REG] = SHAPE_NO_WRITE;
                    tally_next            = 16'd1;
                    delim_next            = 1'b0;
                    open_next             = 1'b1;
                end
                pending_next = b[3:0];
                phase_next   = PH_VALUE;
                fail_req     = fin;
            end
            else
            begin
                fail_req = 1'b1;
            end
        end

        // End of stream: flush the pending group with the updated image.
        if (finish_req)
        begin
            if (open_next && tally_next != '0)
            begin
                entry.has_group = 1'b1;
                for (int i = 0; i < IMAGE_HALF; i++)
                begin
                    entry.image_low[8*i +: 8]  = image_next[i];
                    entry.image_high[8*i +: 8] = image_next[IMAGE_HALF + i];
                end
                entry.span = tally_next;
            end
            open_next       = 1'b0;
            entry.has_term  = 1'b1;
            entry.term_kind = KIND_END;
            phase_next      = PH_DONE;
        end

        // Format error: any pending group is dropped.
        if (fail_req)
        begin
            open_next       = 1'b0;
            entry.has_term  = 1'b1;
            entry.term_kind = KIND_ERROR;
            phase_next      = PH_ERROR;
        end
    end

    assign push = accept && (entry.has_group || entry.has_term);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_left_reg <= HL_W'(HEADER_BYTES);
            phase_reg       <= PH_CMD;
            pending_reg     <= '0;
            tally_reg       <= '0;
            delim_reg       <= 1'b0;
            open_reg        <= 1'b0;
        end
        else if (accept)
        begin
            header_left_reg <= header_left_next;
            phase_reg       <= phase_next;
            pending_reg     <= pending_next;
            tally_reg       <= tally_next;
            delim_reg       <= delim_next;
            open_reg        <= open_next;
        end
    end

    // Register image; it is read by groups, so it is cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
                image_reg[i] <= '0;
        end
        else if (accept)
        begin
            image_reg <= image_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/psg_queue.sv =====
// Small register queue between the parser front end and the record back end.
// Depends on psg_pkg for the entry type.
`default_nettype none

module psg_queue
    import psg_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  entry_t      entry,
    output logic        full,
    input  wire logic   pop,
    output entry_t      head,
    output logic        empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= entry;
    end

endmodule

`default_nettype wire

// ===== hdl/psg_back.sv =====
// Back end: takes queue entries and delivers their records one per request.
// Depends on psg_pkg and psg_record_if.
`default_nettype none

module psg_back
    import psg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_empty,
    input  entry_t       head,
    output logic         pop,
    psg_record_if.source records
);

    entry_t entry_reg;
    logic   group_left_reg;
    logic   term_left_reg;
    logic   busy;
    logic   last_shown;
    logic   handshake;

    assign busy       = group_left_reg || term_left_reg;
    assign last_shown = group_left_reg ^ term_left_reg;
    assign handshake  = records.valid && records.ready;
    assign pop        = !q_empty && (!busy || (handshake && last_shown));

    // Present the group first, then the end or error record.
    assign records.valid       = busy;
    assign records.record_kind = group_left_reg ? KIND_GROUP : entry_reg.term_kind;
    assign records.image_low   = group_left_reg ? entry_reg.image_low : '0;
    assign records.image_high  = group_left_reg ? entry_reg.image_high : '0;
    assign records.frame_span  = group_left_reg ? entry_reg.span : '0;
    assign records.run_end     = group_left_reg ? !term_left_reg : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_left_reg <= 1'b0;
            term_left_reg  <= 1'b0;
        end
        else if (pop)
        begin
            group_left_reg <= head.has_group;
            term_left_reg  <= head.has_term;
        end
        else if (handshake)
        begin
            if (group_left_reg)
                group_left_reg <= 1'b0;
            else
                term_left_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            entry_reg <= head;
    end

endmodule

`default_nettype wire

// ===== hdl/psg_frame_stream_parser_unit.sv =====
// Sound-register dump parser, top level. Takes one byte per cycle while the queue is not full.
// A record is registered in the queue and then in the back-end entry register before
// it is shown. Throughput: one byte per cycle; the back end delivers one record per
// cycle while the receiver is ready, so a byte that causes two records holds the
// output for both. The input stalls only while the queue (two entries by default) is
// full. Reset clears the image and state and reloads the header count.
// Depends on psg_pkg, psg_byte_if, psg_record_if, psg_front, psg_queue, psg_back.
`default_nettype none

module psg_frame_stream_parser_unit
    import psg_pkg::*;
#(
    parameter int HEADER_BYTES = 16,
    parameter int QUEUE_DEPTH  = 2
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    psg_byte_if.sink     bytes,
    psg_record_if.source records
);

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    entry_t entry;
    entry_t head;

    psg_front #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .q_full(q_full),
        .push  (push),
        .entry (entry)
    );

    psg_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .entry(entry),
        .full (q_full),
        .pop  (pop),
        .head (head),
        .empty(q_empty)
    );

    psg_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_empty(q_empty),
        .head   (head),
        .pop    (pop),
        .records(records)
    );

endmodule

`default_nettype wire
